>>> sv/srtm_pkg.sv
// Package for the success-rate trend monitor: payload structs, register
// indexes and fixed constants. No dependencies.
package srtm_pkg;

  localparam int WindowDepth = 64;
  localparam int RateBits    = 16;
  localparam int AddrW       = $clog2(WindowDepth);
  localparam int CntW        = $clog2(WindowDepth + 1);
  localparam logic [16:0] RateOne = 17'd65536;

  localparam logic [1:0] CfgThreshold = 2'd0;
  localparam logic [1:0] CfgWinLen    = 2'd1;
  localparam logic [1:0] CfgInfo      = 2'd2;

  localparam logic [1:0] AlertInfo     = 2'd0;
  localparam logic [1:0] AlertWarning  = 2'd1;
  localparam logic [1:0] AlertError    = 2'd2;
  localparam logic [1:0] AlertCritical = 2'd3;

  typedef struct packed {
    logic [16:0] pass_rate;
    logic [31:0] fix_time;
    logic [31:0] total_count;
    logic [31:0] success_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  alert_level;
    logic        alert_valid;
    logic [2:0]  health_class;
    logic        healthy;
    logic        degrading;
    logic        improving;
    logic [31:0] failed_count;
    logic [16:0] miss_rate;
    logic [16:0] cumulative_rate;
    logic [31:0] peak_time;
  } out_item_t;

endpackage

>>> sv/srtm_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module srtm_ram #(
  parameter int Width = 17,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> sv/success_rate_trend_monitor_unit.sv
// Success-rate trend monitor. One transfer in gives one transfer out, and the
// next item is taken only after the result has been accepted. Each item runs
// through a 64-step restoring divider for the cumulative rate, one write and a
// single read pass over the window memory for the trend and regression sums,
// the slope terms, a step to build the result and one to hand it over. When
// five or more entries are held (after the new one is stored) and the slope
// passes its bound, a bit-serial multiplier forms the three wide fit products
// before the result is built. An output stall delays the next acceptance.
// Depends on srtm_pkg and srtm_ram.
module success_rate_trend_monitor_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  srtm_pkg::in_item_t     in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output srtm_pkg::out_item_t    out_data_o,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [16:0]            cfg_data_i
);
  import srtm_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StDiv, StWrite, StRead, StSum, StTest, StMul, StFin, StOut
  } state_e;

  state_e state_q;
  logic [16:0] thr_q;
  logic [6:0]  wlen_q;
  logic        info_q;

  logic [CntW-1:0]  cnt_q;
  logic [AddrW-1:0] old_q;
  logic [31:0]      peak_q;
  logic [16:0]      run_q;

  in_item_t  item_q;
  logic [16:0] rate_q;
  out_item_t res_q;

  // divider
  logic [63:0] dnum_q;
  logic [32:0] drem_q;
  logic [6:0]  dstep_q;
  logic [31:0] tot_m1;
  logic [48:0] dprod;

  // window pass
  logic [CntW-1:0] idx_q;
  logic            rd_pend_q;
  logic [CntW-1:0] ridx_q;
  logic [16:0]     first_q;
  logic [47:0]     sy_q, sxy_q;
  logic [47:0]     syy_q;
  logic [10:0]     sx_q;
  logic [16:0]     sx2_q;
  logic [23:0]     ixy;
  logic [33:0]     yy;

  // slope terms
  logic [23:0] den_q;
  logic [34:0] mag_q;
  logic        neg_q;
  logic        steep_up_q, steep_dn_q;

  // serial multiply: 128 x 128 low product
  logic [127:0] ma_q, mb_q, macc_q;
  logic [7:0]   mstep_q;
  logic [2:0]   mphase_q;
  logic [127:0] tot_q, lhs_q;
  logic         sdown_q, sup_q;

  logic [AddrW-1:0] raddr, waddr;
  logic [16:0]      rdata;
  logic             we;

  srtm_ram #(.Width(17), .Depth(WindowDepth)) u_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(rate_q),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [CntW-1:0] len_sat;
  always_comb begin
    if (wlen_q < 7'd2) len_sat = CntW'(2);
    else if (wlen_q > 7'(WindowDepth)) len_sat = CntW'(WindowDepth);
    else len_sat = CntW'(wlen_q);
  end

  // Shrink: new count before the write is min(cnt, len-1).
  logic [CntW-1:0] keep;
  logic [CntW-1:0] drop_n;
  assign keep   = (cnt_q >= len_sat) ? len_sat - CntW'(1) : cnt_q;
  assign drop_n = cnt_q - keep;

  assign we    = (state_q == StWrite);
  assign waddr = AddrW'(old_q + AddrW'(cnt_q));
  assign raddr = AddrW'(old_q + AddrW'(idx_q));

  assign tot_m1 = in_data_i.total_count - 32'd1;
  assign dprod  = 49'(run_q) * 49'(tot_m1);

  assign ixy = 24'(rdata) * 24'(ridx_q);
  assign yy  = 34'(rdata) * 34'(rdata);

  // Regression terms from the completed sums; den and the numerator are registered in StSum.
  logic [6:0]  n7;
  logic [23:0] den;
  logic [54:0] nsxy, sxsy, nsyy;
  logic        num_neg;
  logic [54:0] num_mag;
  logic        big;
  assign n7      = 7'(cnt_q);
  assign den     = 24'(n7) * 24'(sx2_q) - 24'(sx_q) * 24'(sx_q);
  assign nsxy    = 55'(n7) * 55'(sxy_q);
  assign sxsy    = 55'(sx_q) * 55'(sy_q);
  assign nsyy    = 55'(n7) * 55'(syy_q);
  assign num_neg = sxsy > nsxy;
  assign num_mag = num_neg ? sxsy - nsxy : nsxy - sxsy;
  // The slope exceeds 0.001 per entry exactly when 1000*|num| > den*RateOne.
  assign big     = 45'(mag_q) * 45'd1000 > 45'({den_q, 16'b0});

  // Drop/trend (at StFin): first_q oldest, rate_q newest.
  logic signed [19:0] dropv;
  logic signed [31:0] span;
  logic steep, mild;
  assign dropv = $signed({3'b0, first_q}) - $signed({3'b0, rate_q});
  assign span  = $signed(32'(cnt_q - CntW'(1))) <<< RateBits;
  assign steep = 32'(dropv) * 32'sd10 > span;
  assign mild  = 32'(dropv) * 32'sd20 > span;

  logic [2:0] hclass;
  always_comb begin
    if (rate_q * 24'd100 >= 24'(RateOne) * 24'd98) hclass = 3'd0;
    else if (rate_q * 24'd100 >= 24'(RateOne) * 24'd95) hclass = 3'd1;
    else if (rate_q * 24'd100 >= 24'(RateOne) * 24'd90) hclass = 3'd2;
    else if (rate_q * 24'd100 >= 24'(RateOne) * 24'd80) hclass = 3'd3;
    else hclass = 3'd4;
  end

  logic [33:0] dtrial;
  assign dtrial = {drem_q, dnum_q[63]} - {2'b0, item_q.total_count};

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= 17'd58982;
      wlen_q <= 7'd64;
      info_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgThreshold: thr_q  <= cfg_data_i;
        CfgWinLen:    wlen_q <= cfg_data_i[6:0];
        CfgInfo:      info_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      old_q   <= '0;
      peak_q  <= '0;
      run_q   <= '0;
      rd_pend_q <= 1'b0;
      item_q  <= '0;
      rate_q  <= '0;
      res_q   <= '0;
      dnum_q  <= '0;
      drem_q  <= '0;
      dstep_q <= '0;
      idx_q   <= '0;
      ridx_q  <= '0;
      first_q <= '0;
      sy_q    <= '0;
      sxy_q   <= '0;
      syy_q   <= '0;
      sx_q    <= '0;
      sx2_q   <= '0;
      den_q   <= '0;
      mag_q   <= '0;
      neg_q   <= 1'b0;
      steep_up_q <= 1'b0;
      steep_dn_q <= 1'b0;
      ma_q    <= '0;
      mb_q    <= '0;
      macc_q  <= '0;
      mstep_q <= '0;
      mphase_q <= '0;
      tot_q   <= '0;
      lhs_q   <= '0;
      sdown_q <= 1'b0;
      sup_q   <= 1'b0;
    end else begin
      case (state_q)
        StIdle: if (in_valid_i) begin
          item_q <= in_data_i;
          rate_q <= (in_data_i.pass_rate > RateOne) ? RateOne
                                                    : in_data_i.pass_rate;
          if (in_data_i.fix_time > peak_q) peak_q <= in_data_i.fix_time;
          dnum_q  <= 64'(dprod);
          drem_q  <= '0;
          dstep_q <= '0;
          state_q <= StDiv;
        end
        StDiv: begin
          if (dstep_q == 7'd0) begin
            // add rate and half the divisor once, before shifting
            dnum_q <= dnum_q + 64'(rate_q) + 64'(item_q.total_count >> 1);
            dstep_q <= 7'd1;
          end else if (dstep_q <= 7'd64) begin
            dnum_q <= {dnum_q[62:0], ~dtrial[33]};
            drem_q <= dtrial[33] ? {drem_q[31:0], dnum_q[63]} : dtrial[32:0];
            dstep_q <= dstep_q + 7'd1;
          end else begin
            if (item_q.total_count != 32'd0) run_q <= dnum_q[16:0];
            old_q <= AddrW'(old_q + AddrW'(drop_n));
            cnt_q <= keep;
            state_q <= StWrite;
          end
        end
        StWrite: begin
          cnt_q <= cnt_q + CntW'(1);
          idx_q <= '0;
          rd_pend_q <= 1'b0;
          sy_q <= '0; sxy_q <= '0; syy_q <= '0;
          sx_q <= '0; sx2_q <= '0;
          state_q <= StRead;
        end
        StRead: begin
          // One read issued per cycle; the data is accumulated in the next cycle.
          rd_pend_q <= (idx_q < cnt_q);
          ridx_q <= idx_q;
          if (idx_q < cnt_q) idx_q <= idx_q + CntW'(1);
          if (rd_pend_q) begin
            if (ridx_q == '0) first_q <= rdata;
            sy_q  <= sy_q + 48'(rdata);
            sxy_q <= sxy_q + 48'(ixy);
            syy_q <= syy_q + 48'(yy);
            sx_q  <= sx_q + 11'(ridx_q);
            sx2_q <= sx2_q + 17'(ridx_q) * 17'(ridx_q);
          end
          if (!rd_pend_q && idx_q == cnt_q && idx_q != '0) state_q <= StSum;
        end
        StSum: begin
          den_q <= den;
          mag_q <= 35'(num_mag);
          neg_q <= num_neg;
          state_q <= StTest;
        end
        StTest: begin
          sdown_q <= 1'b0; sup_q <= 1'b0;
          steep_up_q <= !neg_q && big;
          steep_dn_q <= neg_q && big;
          // tot = n*syy - sy*sy, staged through the serial multiplier
          ma_q <= 128'(sy_q); mb_q <= 128'(sy_q); macc_q <= '0;
          mstep_q <= '0; mphase_q <= '0;
          state_q <= (cnt_q >= CntW'(5) && big) ? StMul : StFin;
        end
        StMul: begin
          if (mstep_q != 8'd128) begin
            if (mb_q[0]) macc_q <= macc_q + ma_q;
            ma_q <= ma_q << 1;
            mb_q <= mb_q >> 1;
            mstep_q <= mstep_q + 8'd1;
          end else begin
            mstep_q <= '0;
            macc_q <= '0;
            mphase_q <= mphase_q + 3'd1;
            case (mphase_q)
              3'd0: begin
                tot_q <= 128'(nsyy) - macc_q;
                ma_q <= 128'(mag_q); mb_q <= 128'(mag_q);
              end
              3'd1: begin
                lhs_q <= macc_q * 128'd10;
                ma_q <= tot_q; mb_q <= 128'(den_q);
              end
              default: begin
                if (lhs_q > macc_q * 128'd7) begin
                  sdown_q <= steep_dn_q; sup_q <= steep_up_q;
                end
                state_q <= StFin;
              end
            endcase
          end
        end
        StFin: begin
          if (cnt_q >= CntW'(2)) begin
            if (rate_q < thr_q) res_q.alert_level <= steep ? AlertCritical : AlertError;
            else res_q.alert_level <= mild ? AlertWarning : AlertInfo;
            res_q.healthy <= (rate_q >= thr_q) && !steep &&
              (36'(item_q.fix_time) * 36'd10 <= 36'(peak_q) * 36'd9);
            res_q.alert_valid <= !(rate_q >= thr_q && !mild && !info_q);
          end else begin
            res_q.alert_level <= AlertError;
            res_q.healthy <= 1'b0;
            res_q.alert_valid <= 1'b1;
          end
          res_q.health_class <= hclass;
          res_q.degrading <= sdown_q;
          res_q.improving <= sup_q;
          res_q.failed_count <= (item_q.total_count > item_q.success_count) ?
            item_q.total_count - item_q.success_count : 32'd0;
          res_q.miss_rate <= RateOne - rate_q;
          res_q.cumulative_rate <= run_q;
          res_q.peak_time <= peak_q;
          state_q <= StOut;
        end
        StOut: if (out_ready_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(WindowDepth)) else $error("window count overflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(res_q))
    else $error("result changed while stalled");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready during output");
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(res_q.degrading && res_q.improving))
    else $error("both trend flags set");
endmodule
